// ----- hdl/tcw_pkg.sv -----
package tcw_pkg;

   // word kinds on the request channel
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // character codes with a meaning of their own
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // register indexes
   localparam logic [1:0] CSR_ATTR = 2'd0;
   localparam logic [1:0] CSR_COLS = 2'd1;
   localparam logic [1:0] CSR_ROWS = 2'd2;

   localparam logic [7:0] ATTR_RESET = 8'h50;
   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [6:0] ROWS_RESET = 7'd25;

   typedef struct packed {
      logic        kind;
      logic [7:0]  char_code;
      logic [11:0] cell_index;
   } req_word_type;

   typedef struct packed {
      logic [11:0] cursor_pos;
      logic [15:0] cell_value;
      logic        scrolled;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] data;
   } csr_word_type;

endpackage

// ----- hdl/tcw_if.sv -----
interface tcw_req_if;
   logic                 valid;
   logic                 ready;
   tcw_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tcw_rsp_if;
   logic                 valid;
   logic                 ready;
   tcw_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface tcw_csr_if;
   logic                 valid;
   logic                 ready;
   tcw_pkg::csr_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// ----- hdl/tcw_cell_ram.sv -----
module tcw_cell_ram #(
   parameter int DEPTH = 4096,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [15:0]       wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [15:0] cells [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= cells[rd_addr];
   end

endmodule

// ----- hdl/tcw_mac.sv -----
// registered a * b + c, shared by every address and size product
module tcw_mac #(
   parameter int OPA_W = 7,
   parameter int OPB_W = 8,
   parameter int OPC_W = 8,
   parameter int RES_W = 15
) (
   input  logic             clock,
   input  logic [OPA_W-1:0] op_a,
   input  logic [OPB_W-1:0] op_b,
   input  logic [OPC_W-1:0] op_c,
   output logic [RES_W-1:0] result
);

   logic [RES_W-1:0] result_ff;
   logic [RES_W-1:0] result_in;

   assign result_in = RES_W'(op_a) * RES_W'(op_b) + RES_W'(op_c);
   assign result = result_ff;

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

// ----- hdl/text_console_char_writer.sv -----
// Text console character writer. Each request word either puts one character
// at the cursor (kind 0) or reads one screen cell for refresh (kind 1); every
// request gives exactly one response word with the linear cursor position.
// A read or an ordinary character is accepted while the shared multiply-add
// unit forms row * cols + col; the execute state then writes or reads the
// cell store, updates the cursor for a character and loads the response
// register, or goes to a hold state while that register still waits. A character
// that scrolls next forms offset, kept and total sizes and the final cursor
// on the same unit, moves the single-port-write cell store up and blanks the
// bottom, one cell per cycle, then loads the response register once free.
// After reset a clearing pass zeroes every cell before the first request is
// taken; register writes are taken always. A finished response sits in an
// output register, so the next request is accepted while it waits.
module text_console_char_writer #(
   parameter int CELLS = 4096,
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic     clock,
   input  logic     reset,
   tcw_req_if.sink   req_if,
   tcw_rsp_if.source rsp_if,
   tcw_csr_if.sink   csr_if
);
   import tcw_pkg::*;

   localparam int CW0 = $clog2(MAX_COLS);
   localparam int CLW = CW0 + 1;
   localparam int RW0 = $clog2(MAX_ROWS);
   localparam int RW1 = RW0 + 1;
   localparam int PW = RW1 + CLW;
   localparam int AW = $clog2(CELLS);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_MUL_OFF,
      ST_MUL_KEEP,
      ST_MUL_TOTAL,
      ST_MUL_POS,
      ST_COPY,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;

   logic [7:0]     attr_ff, attr_in;
   logic [7:0]     cols_ff, cols_in;
   logic [6:0]     rows_ff, rows_in;
   logic [CW0-1:0] cursor_col_ff, cursor_col_in;
   logic [RW0-1:0] cursor_row_ff, cursor_row_in;
   logic [AW-1:0]  clr_ff, clr_in;

   logic           kind_ff, kind_in;
   logic [7:0]     char_ff, char_in;
   logic           rd_ok_ff, rd_ok_in;

   logic [RW1-1:0] lines_ff, lines_in;
   logic [PW-1:0]  off_ff, off_in;
   logic [PW-1:0]  keep_ff, keep_in;
   logic [PW-1:0]  total_ff, total_in;
   logic [PW-1:0]  cnt_ff, cnt_in;

   logic           pend_valid_ff, pend_valid_in;
   logic [AW-1:0]  pend_dst_ff, pend_dst_in;
   logic           pend_ok_ff, pend_ok_in;
   logic           pend_copy_ff, pend_copy_in;
   logic           pend_src_ok_ff, pend_src_ok_in;

   rsp_word_type   res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_word_type   rsp_word_ff, rsp_word_in;

   logic [CLW-1:0] cols_eff;
   logic [RW1-1:0] rows_eff;

   logic [RW1-1:0] mac_a;
   logic [CLW-1:0] mac_b;
   logic [CLW-1:0] mac_c;
   logic [PW-1:0]  mac_res;

   logic           we;
   logic [AW-1:0]  waddr;
   logic [15:0]    wdata;
   logic [AW-1:0]  raddr;
   logic [15:0]    rdata;

   logic [CLW-1:0] col_x;
   logic [CLW-1:0] ncol;
   logic           put;
   logic           lf;
   logic           wrap;
   logic [RW1-1:0] nrow;
   logic           do_scroll;
   logic [RW1-1:0] lines_raw;
   logic [PW-1:0]  pos_inc;
   logic [PW:0]    src;
   logic           out_free;
   logic           accept;
   rsp_word_type   result;

   tcw_mac #(
      .OPA_W(RW1),
      .OPB_W(CLW),
      .OPC_W(CLW),
      .RES_W(PW)
   ) u_mac (
      .clock (clock),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .op_c  (mac_c),
      .result(mac_res)
   );

   tcw_cell_ram #(
      .DEPTH (CELLS),
      .ADDR_W(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_addr(raddr),
      .rd_data(rdata)
   );

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.word = rsp_word_ff;

   assign accept = req_if.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // zero geometry acts as 1, oversize clamps to the maximum
   always_comb begin
      if (cols_ff == 8'd0) begin
         cols_eff = CLW'(1);
      end else if (int'(cols_ff) > MAX_COLS) begin
         cols_eff = CLW'(MAX_COLS);
      end else begin
         cols_eff = CLW'(cols_ff);
      end
      if (rows_ff == 7'd0) begin
         rows_eff = RW1'(1);
      end else if (int'(rows_ff) > MAX_ROWS) begin
         rows_eff = RW1'(MAX_ROWS);
      end else begin
         rows_eff = RW1'(rows_ff);
      end
   end

   // cursor step for the held character
   always_comb begin
      col_x = CLW'(cursor_col_ff);
      ncol = col_x;
      put = 1'b0;
      lf = 1'b0;
      case (char_ff)
         CH_BS: begin
            if (col_x != '0) begin
               ncol = col_x - CLW'(1);
            end
         end
         CH_TAB: ncol = (col_x + CLW'(8)) & ~CLW'(7);
         CH_CR: ncol = '0;
         CH_LF: begin
            ncol = '0;
            lf = 1'b1;
         end
         default: begin
            if (char_ff >= CH_SPACE) begin
               ncol = col_x + CLW'(1);
               put = 1'b1;
            end
         end
      endcase
      wrap = (ncol >= cols_eff);
      if (wrap) begin
         ncol = '0;
      end
      nrow = RW1'(cursor_row_ff) + RW1'(lf) + RW1'(wrap);
      do_scroll = (nrow >= rows_eff);
      lines_raw = nrow - rows_eff + RW1'(1);
      // old address minus old column, plus a line if the row moved, plus new column
      pos_inc = mac_res - PW'(cursor_col_ff) + ((lf || wrap) ? PW'(cols_eff) : '0)
                + PW'(ncol);
   end

   assign src = (PW + 1)'(cnt_ff) + (PW + 1)'(off_ff);

   always_comb begin
      mac_a = RW1'(cursor_row_ff);
      mac_b = cols_eff;
      mac_c = CLW'(cursor_col_ff);
      case (state_ff)
         ST_MUL_OFF: begin
            mac_a = lines_ff;
            mac_c = '0;
         end
         ST_MUL_KEEP: begin
            mac_a = rows_eff - lines_ff;
            mac_c = '0;
         end
         ST_MUL_TOTAL: begin
            mac_a = rows_eff;
            mac_c = '0;
         end
         ST_MUL_POS: mac_a = rows_eff - RW1'(1);
         default: ;
      endcase
   end

   // one write port: clearing pass, character, or the delayed scroll move
   always_comb begin
      we = 1'b0;
      waddr = AW'(mac_res);
      wdata = {attr_ff, char_ff};
      if (state_ff == ST_CLEAR) begin
         we = 1'b1;
         waddr = clr_ff;
         wdata = '0;
      end else if (state_ff == ST_EXEC) begin
         we = (kind_ff == KIND_PUT) && put && (int'(mac_res) < CELLS);
      end else if (pend_valid_ff) begin
         we = pend_ok_ff;
         waddr = pend_dst_ff;
         if (pend_copy_ff) begin
            wdata = pend_src_ok_ff ? rdata : '0;
         end else begin
            wdata = {attr_ff, CH_SPACE};
         end
      end
   end

   always_comb begin
      raddr = AW'(src);
      if (state_ff == ST_IDLE) begin
         raddr = AW'(req_if.word.cell_index);
      end
   end

   always_comb begin
      state_in = state_ff;
      attr_in = attr_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      clr_in = clr_ff;
      kind_in = kind_ff;
      char_in = char_ff;
      rd_ok_in = rd_ok_ff;
      lines_in = lines_ff;
      off_in = off_ff;
      keep_in = keep_ff;
      total_in = total_ff;
      cnt_in = cnt_ff;
      pend_valid_in = 1'b0;
      pend_dst_in = AW'(cnt_ff);
      pend_ok_in = (int'(cnt_ff) < CELLS);
      pend_copy_in = (cnt_ff < keep_ff);
      pend_src_ok_in = (int'(src) < CELLS);
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in = rsp_word_ff;
      result = res_ff;

      if (csr_if.valid) begin
         case (csr_if.word.index)
            CSR_ATTR: attr_in = csr_if.word.data;
            CSR_COLS: cols_in = csr_if.word.data;
            CSR_ROWS: rows_in = csr_if.word.data[6:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = req_if.word.kind;
               char_in = req_if.word.char_code;
               rd_ok_in = (int'(req_if.word.cell_index) < CELLS);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (kind_ff == KIND_READ) begin
               result.cursor_pos = 12'(mac_res);
               result.cell_value = rd_ok_ff ? rdata : '0;
               result.scrolled = 1'b0;
            end else begin
               result.cursor_pos = 12'(pos_inc);
               result.cell_value = '0;
               result.scrolled = do_scroll;
               cursor_col_in = CW0'(ncol);
               cursor_row_in = RW0'(nrow);
            end
            if (kind_ff == KIND_PUT && do_scroll) begin
               cursor_row_in = RW0'(rows_eff - RW1'(1));
               lines_in = (lines_raw > rows_eff) ? rows_eff : lines_raw;
               res_in = result;
               state_in = ST_MUL_OFF;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = result;
               state_in = ST_IDLE;
            end else begin
               res_in = result;
               state_in = ST_HOLD;
            end
         end
         ST_MUL_OFF: state_in = ST_MUL_KEEP;
         ST_MUL_KEEP: begin
            off_in = mac_res;
            state_in = ST_MUL_TOTAL;
         end
         ST_MUL_TOTAL: begin
            keep_in = mac_res;
            state_in = ST_MUL_POS;
         end
         ST_MUL_POS: begin
            total_in = mac_res;
            cnt_in = '0;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            // final cursor position lands on the first copy cycle
            if (cnt_ff == '0) begin
               res_in.cursor_pos = 12'(mac_res);
            end
            if (cnt_ff < total_ff) begin
               pend_valid_in = 1'b1;
               cnt_in = cnt_ff + PW'(1);
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         attr_ff <= ATTR_RESET;
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         clr_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         attr_ff <= attr_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         clr_ff <= clr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      char_ff <= char_in;
      rd_ok_ff <= rd_ok_in;
      lines_ff <= lines_in;
      off_ff <= off_in;
      keep_ff <= keep_in;
      total_ff <= total_in;
      cnt_ff <= cnt_in;
      pend_dst_ff <= pend_dst_in;
      pend_ok_ff <= pend_ok_in;
      pend_copy_ff <= pend_copy_in;
      pend_src_ok_ff <= pend_src_ok_in;
      res_ff <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

`ifndef NO_ASSERTIONS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> state_ff == ST_EXEC)
      else $error("accepted word did not enter execute");

   a_copy_sizes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> off_ff != '0 && keep_ff < total_ff)
      else $error("scroll move with zero offset or no blank line");

   a_pend_in_copy: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> state_ff == ST_COPY)
      else $error("scroll write outside the move");

   a_scroll_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.word.scrolled |-> rsp_if.word.cell_value == '0)
      else $error("scrolled word carries a cell value");
`endif

endmodule

// ----- tb/tcw_console_scoreboard.sv -----
`timescale 1ns / 100ps

// Watches the three channels of the console writer, keeps its own copy of the
// screen store, cursor and registers, and checks every response word against
// the oldest predicted one.
module tcw_console_scoreboard #(
   parameter int CELLS = 4096,
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic clock,
   input  logic reset,
   tcw_req_if   req_mon,
   tcw_rsp_if   rsp_mon,
   tcw_csr_if   csr_mon,
   output int   mismatches,
   output int   words_owed
);
   import tcw_pkg::*;

   logic [7:0]   attr_reg;
   logic [7:0]   cols_reg;
   logic [6:0]   rows_reg;
   int           cur_col;
   int           cur_row;
   logic [15:0]  screen [CELLS];
   rsp_word_type owed_rsp [$];

   function automatic int cols_now();
      int c;
      c = (cols_reg == 0) ? 1 : int'(cols_reg);
      if (c > MAX_COLS) c = MAX_COLS;
      return c;
   endfunction

   function automatic int rows_now();
      int r;
      r = (rows_reg == 0) ? 1 : int'(rows_reg);
      if (r > MAX_ROWS) r = MAX_ROWS;
      return r;
   endfunction

   // addresses past the store read as zero and swallow writes
   function automatic logic [15:0] cell_at(int addr);
      return (addr < CELLS) ? screen[addr] : 16'h0000;
   endfunction

   function automatic void cell_set(int addr, logic [15:0] v);
      if (addr < CELLS) screen[addr] = v;
   endfunction

   // cursor below the last row: move lines up, blank the freed ones
   function automatic logic scroll_up(int cols, int rows);
      int          lines;
      int          keep;
      logic [15:0] blank;
      if (cur_row < rows) return 1'b0;
      lines = cur_row - rows + 1;
      if (lines > rows) lines = rows;
      keep = (rows - lines) * cols;
      for (int i = 0; i < keep; i++) cell_set(i, cell_at(i + lines * cols));
      blank = {attr_reg, CH_SPACE};
      for (int i = keep; i < rows * cols; i++) cell_set(i, blank);
      cur_row = rows - 1;
      return 1'b1;
   endfunction

   function automatic rsp_word_type console_step(req_word_type w);
      int           cols;
      int           rows;
      rsp_word_type r;
      cols = cols_now();
      rows = rows_now();
      r = '0;
      if (w.kind == KIND_READ) begin
         r.cell_value = cell_at(int'(w.cell_index));
      end else begin
         case (w.char_code)
            CH_BS: begin
               if (cur_col != 0) cur_col--;
            end
            CH_TAB: begin
               cur_col = (cur_col + 8) & ~7;
            end
            CH_CR: begin
               cur_col = 0;
            end
            CH_LF: begin
               cur_col = 0;
               cur_row++;
            end
            default: begin
               if (w.char_code >= CH_SPACE) begin
                  cell_set(cur_row * cols + cur_col, {attr_reg, w.char_code});
                  cur_col++;
               end
            end
         endcase
         if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
         end
         r.scrolled = scroll_up(cols, rows);
      end
      r.cursor_pos = 12'(cur_row * cols + cur_col);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("%0t tcw check: %s got %h want %h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         attr_reg = ATTR_RESET;
         cols_reg = COLS_RESET;
         rows_reg = ROWS_RESET;
         cur_col = 0;
         cur_row = 0;
         for (int i = 0; i < CELLS; i++) screen[i] = 16'h0000;
         owed_rsp.delete();
         mismatches = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.word.index)
               CSR_ATTR: attr_reg = csr_mon.word.data;
               CSR_COLS: cols_reg = csr_mon.word.data;
               CSR_ROWS: rows_reg = csr_mon.word.data[6:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.word;
            if (owed_rsp.size() == 0) begin
               report_mismatch("response word with none owed", 16'(got.cursor_pos), 16'h0);
            end else begin
               want = owed_rsp.pop_front();
               if (got.cursor_pos !== want.cursor_pos)
                  report_mismatch("cursor_pos", 16'(got.cursor_pos), 16'(want.cursor_pos));
               if (got.cell_value !== want.cell_value)
                  report_mismatch("cell_value", got.cell_value, want.cell_value);
               if (got.scrolled !== want.scrolled)
                  report_mismatch("scrolled", 16'(got.scrolled), 16'(want.scrolled));
            end
         end
         if (req_mon.valid && req_mon.ready) owed_rsp.push_back(console_step(req_mon.word));
      end
      words_owed = owed_rsp.size();
   end

endmodule

// ----- tb/tb_text_console_char_writer.sv -----
`timescale 1ns / 100ps

module tb_text_console_char_writer;
   import tcw_pkg::*;

   localparam int RUN_LIMIT = 4_000_000;
   localparam int STORE_CELLS = 4096;
   localparam logic [1:0] CSR_SPARE = 2'd3;  // no register behind it

   typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_SKIP, DRAIN_SLOW} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();
   tcw_csr_if csr_if ();

   int             mismatches;
   int             words_owed;
   int             cycles = 0;
   int             cols_eff;
   int             rows_eff;
   int             burst_left = 0;
   bit             steady = 1'b0;
   int             drain_count = 0;
   drain_mode_type drain_mode = DRAIN_FREE;

   text_console_char_writer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   tcw_console_scoreboard chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .csr_mon    (csr_if),
      .mismatches (mismatches),
      .words_owed (words_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("tb_text_console_char_writer: done, errors");
         $finish;
      end
   end

   // response side: stall pattern redrawn at random among the four drain modes
   always @(negedge clock) begin
      drain_count++;
      if (drain_count % 48 == 0) drain_mode = drain_mode_type'($urandom_range(0, 3));
      case (drain_mode)
         DRAIN_FREE: rsp_if.ready = 1'b1;
         DRAIN_COIN: rsp_if.ready = 1'($urandom_range(0, 1));
         DRAIN_SKIP: rsp_if.ready = (drain_count % 4) != 0;
         default:    rsp_if.ready = (drain_count % 16) < 6;
      endcase
   end

   task automatic send_req(req_word_type w);
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.word = w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic idle_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
   endtask

   // bursts of random length with random gaps, none in steady phases
   task automatic offer(req_word_type w);
      if (burst_left == 0) begin
         if (!steady) idle_req($urandom_range(0, 6));
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_req(w);
   endtask

   task automatic put(logic [7:0] ch);
      req_word_type w;
      w.kind = KIND_PUT;
      w.char_code = ch;
      w.cell_index = 12'($urandom_range(0, STORE_CELLS - 1));
      offer(w);
   endtask

   task automatic peek(logic [11:0] idx);
      req_word_type w;
      w.kind = KIND_READ;
      w.char_code = 8'($urandom_range(0, 255));
      w.cell_index = idx;
      offer(w);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.word.index = idx;
      csr_if.word.data = val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic drain_all();
      @(negedge clock);
      req_if.valid = 1'b0;
      burst_left = 0;
      while (words_owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(logic [7:0] attr, logic [7:0] cols, logic [6:0] rows);
      drain_all();
      write_csr(CSR_ATTR, attr);
      write_csr(CSR_COLS, cols);
      write_csr(CSR_ROWS, rows);
      cols_eff = (cols == 0) ? 1 : ((cols > 128) ? 128 : int'(cols));
      rows_eff = (rows == 0) ? 1 : ((rows > 64) ? 64 : int'(rows));
   endtask

   // mostly printable text with line control, some stray codes and reads
   function automatic req_word_type random_req();
      req_word_type w;
      int           pick;
      int           span;
      w.kind = KIND_PUT;
      w.char_code = 8'($urandom_range(0, 255));
      w.cell_index = 12'($urandom_range(0, STORE_CELLS - 1));
      pick = $urandom_range(0, 99);
      if (pick < 50) w.char_code = 8'($urandom_range(CH_SPACE, 255));
      else if (pick < 58) w.char_code = CH_LF;
      else if (pick < 63) w.char_code = CH_CR;
      else if (pick < 68) w.char_code = CH_BS;
      else if (pick < 73) w.char_code = CH_TAB;
      else if (pick < 78) w.char_code = 8'($urandom_range(0, CH_SPACE - 1));
      else begin
         w.kind = KIND_READ;
         if (pick < 92) begin
            span = cols_eff * rows_eff;
            if (span > STORE_CELLS) span = STORE_CELLS;
            w.cell_index = 12'($urandom_range(0, span - 1));
         end
      end
      return w;
   endfunction

   task automatic run_random(int n);
      repeat (n) offer(random_req());
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.word = '0;
      csr_if.valid = 1'b0;
      csr_if.word = '0;
      rsp_if.ready = 1'b0;
      cols_eff = 80;
      rows_eff = 25;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset geometry and attribute, cleared store
      put(8'h5A);
      put(CH_LF);
      peek(12'h000);
      peek(12'hFFF);

      // tiny screen: backspace at the margin, tab wrap, scrolls
      configure(8'hFF, 8'd8, 7'd2);
      put(CH_BS);
      put(8'h41);
      put(8'hFF);
      put(CH_SPACE);
      put(CH_BS);
      put(8'h1F);
      put(8'h00);
      put(CH_TAB);
      put(8'h7E);
      put(CH_CR);
      put(CH_TAB);
      put(CH_LF);
      put(8'h1B);
      peek(12'h000);
      peek(12'h008);
      peek(12'h00F);
      peek(12'h010);
      peek(12'hFFF);
      peek(12'h800);

      // zero geometry acts as a single cell
      steady = 1'b1;
      configure(8'h00, 8'd0, 7'd0);
      run_random(40);
      steady = 1'b0;

      // oversized geometry, larger than the store; several one-line scrolls
      configure(8'hFF, 8'd255, 7'd127);
      write_csr(CSR_SPARE, 8'($urandom_range(0, 255)));
      repeat (20) put(8'($urandom_range(CH_SPACE, 255)));
      repeat (66) put(CH_LF);
      repeat (6) peek(12'($urandom_range(0, STORE_CELLS - 1)));
      repeat (6) put(8'($urandom_range(CH_SPACE, 255)));

      // exactly fills the store, then the reset geometry
      configure(8'h50, 8'd128, 7'd32);
      run_random(40);
      configure(ATTR_RESET, COLS_RESET, ROWS_RESET);
      run_random(40);

      for (int p = 0; p < 12; p++) begin
         steady = (p % 4) == 0;
         configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 24)),
                   7'($urandom_range(0, 10)));
         run_random(60);
      end
      steady = 1'b0;

      drain_all();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb_text_console_char_writer: done, clean");
      end else begin
         $display("tb_text_console_char_writer: done, errors");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/tcw_pkg.sv
hdl/tcw_if.sv
hdl/tcw_cell_ram.sv
hdl/tcw_mac.sv
hdl/text_console_char_writer.sv
tb/tcw_console_scoreboard.sv
tb/tb_text_console_char_writer.sv
